FILE: src/salc_pkg.sv
// Package for the set-associative LRU cache model: field widths, codes,
// payload structs and parameter defaults.
// No dependencies; the top level in src refers to it by scoped names.
package salc_pkg;

   // Default sizing of the cache array.
   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;

   // Fixed field widths.
   localparam int CMD_W   = 2;
   localparam int ADDR_W  = 64;
   localparam int TAG_W   = 62;
   localparam int CNT_W   = 32;
   localparam int OUT_W   = 2;

   // Configuration register widths and reset values.
   localparam int SET_BITS_W   = 3;
   localparam int WAY_COUNT_W  = 4;
   localparam int BLOCK_BITS_W = 6;
   localparam int CSR_DATA_W   = 6;
   localparam int CSR_IDX_W    = 2;
   localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
   localparam logic [WAY_COUNT_W-1:0]  WAY_COUNT_RST  = 4'd1;
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;

   // Widths used when clamping the configuration.
   localparam int SB_W    = 4;   // effective set bit count
   localparam int WC_W    = 5;   // effective way count
   localparam int SHIFT_W = 7;   // block bits plus set bits

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_WAY_COUNT  = 2'd1,
      CSR_BLOCK_BITS = 2'd2
   } csr_index_type;

   // Access commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_MODIFY = 2'd2,
      CMD_IFETCH = 2'd3
   } cmd_type;

   // Access outcomes.
   typedef enum logic [OUT_W-1:0] {
      OUT_HIT     = 2'd0,
      OUT_FILL    = 2'd1,
      OUT_EVICT   = 2'd2,
      OUT_IGNORED = 2'd3
   } outcome_type;

   // One trace access.
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
   } req_type;

   // One access result with the running totals.
   typedef struct packed {
      logic [OUT_W-1:0] outcome;
      logic             second_hit;
      logic [CNT_W-1:0] hit_total;
      logic [CNT_W-1:0] miss_total;
      logic [CNT_W-1:0] evict_total;
   } rsp_type;

endpackage

FILE: src/salc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/set_assoc_lru_cache_sim_unit.sv
// Set-associative cache simulator with true LRU replacement, top level.
// Depends on salc_pkg and salc_ram.
//
// An accepted access reads, in its transfer cycle, the whole set (all ways with
// valid, tag and age rank) from one RAM row; the next cycle compares the tags of
// all ways in parallel, picks the hit, empty or victim way, ages the other
// lines, writes the row back unless it is an instruction fetch and loads the
// result register. No new access is taken until this read-modify-write is
// through, nor while a result waits. A modify needs no second pass since its
// second access always hits the line just touched. Only one access is in flight,
// so a following access to the same set always reads the written-back row. Sets
// never written since reset read as empty through one flag per set, so there is
// no clearing pass. Configuration does not flush the cache.
module set_assoc_lru_cache_sim_unit #(
   parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  salc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output salc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [salc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SETS   = 1 << MAX_SET_BITS;
   localparam int SET_W  = MAX_SET_BITS;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int AGE_W  = WAY_W;
   localparam int ENT_W  = 1 + salc_pkg::TAG_W + AGE_W;
   localparam int ROW_W  = MAX_WAYS * ENT_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   // Control and configuration registers.
   state_type                            state_ff, state_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [salc_pkg::CNT_W-1:0]           hits_ff, hits_in;
   logic [salc_pkg::CNT_W-1:0]           misses_ff, misses_in;
   logic [salc_pkg::CNT_W-1:0]           evicts_ff, evicts_in;
   logic [SETS-1:0]                      row_live_ff, row_live_in;
   logic [salc_pkg::SET_BITS_W-1:0]      set_bits_ff, set_bits_in;
   logic [salc_pkg::WAY_COUNT_W-1:0]     way_count_ff, way_count_in;
   logic [salc_pkg::BLOCK_BITS_W-1:0]    block_bits_ff, block_bits_in;

   // Payload registers of the access in flight and of the result.
   logic [salc_pkg::TAG_W-1:0]           tag_ff, tag_in;
   logic [SET_W-1:0]                     set_ff, set_in;
   logic                                 ign_ff, ign_in;
   logic                                 mod_ff, mod_in;
   salc_pkg::rsp_type                    rsp_data_ff, rsp_data_in;

   // Address split and handshake.
   logic                                 req_xfer;
   logic [salc_pkg::SB_W-1:0]            sb_eff;
   logic [salc_pkg::SHIFT_W-1:0]         split_shift;
   logic [salc_pkg::ADDR_W-1:0]          addr_blk;
   logic [SET_W-1:0]                     set_mask;
   logic [salc_pkg::WC_W-1:0]            ways_eff;

   // Set RAM interface.
   logic                                 ram_we;
   logic [ROW_W-1:0]                     ram_rdata;
   logic [ROW_W-1:0]                     row_word;
   logic [ROW_W-1:0]                     row_new;

   // Lookup results.
   logic [MAX_WAYS-1:0]                  way_act;
   logic [MAX_WAYS-1:0]                  way_vld;
   logic [salc_pkg::TAG_W-1:0]           way_tag [MAX_WAYS];
   logic [AGE_W-1:0]                     way_age [MAX_WAYS];
   logic                                 hit_any;
   logic                                 empty_any;
   logic [WAY_W-1:0]                     keep_way;
   salc_pkg::outcome_type                access_out;

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Clamp the configuration to the sizes the array supports.
   always_comb begin
      if ({1'b0, set_bits_ff} > salc_pkg::SB_W'(MAX_SET_BITS)) begin
         sb_eff = salc_pkg::SB_W'(MAX_SET_BITS);
      end else begin
         sb_eff = salc_pkg::SB_W'(set_bits_ff);
      end
      if (way_count_ff == '0) begin
         ways_eff = salc_pkg::WC_W'(1);
      end else if ({1'b0, way_count_ff} > salc_pkg::WC_W'(MAX_WAYS)) begin
         ways_eff = salc_pkg::WC_W'(MAX_WAYS);
      end else begin
         ways_eff = salc_pkg::WC_W'(way_count_ff);
      end
   end

   // Split the incoming address into set index and tag.
   always_comb begin
      split_shift = salc_pkg::SHIFT_W'(block_bits_ff) + salc_pkg::SHIFT_W'(sb_eff);
      addr_blk    = req_data.addr >> block_bits_ff;
      set_mask    = ~({SET_W{1'b1}} << sb_eff);
      set_in      = SET_W'(addr_blk) & set_mask;
      if (split_shift >= salc_pkg::SHIFT_W'(salc_pkg::ADDR_W)) begin
         tag_in = '0;
      end else begin
         tag_in = salc_pkg::TAG_W'(req_data.addr >> split_shift);
      end
      ign_in = (req_data.cmd == salc_pkg::CMD_IFETCH);
      mod_in = (req_data.cmd == salc_pkg::CMD_MODIFY);
   end

   // One row per set holds all ways.
   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_set_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (set_ff),
      .wdata (row_new),
      .re    (req_xfer),
      .raddr (set_in),
      .rdata (ram_rdata)
   );

   // A set never written since reset reads as all lines empty.
   assign row_word = row_live_ff[set_ff] ? ram_rdata : '0;

   // Unpack the row into its ways.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         way_vld[w] = row_word[w*ENT_W + ENT_W - 1];
         way_tag[w] = row_word[w*ENT_W + AGE_W +: salc_pkg::TAG_W];
         way_age[w] = row_word[w*ENT_W +: AGE_W];
         way_act[w] = salc_pkg::WC_W'(w) < ways_eff;
      end
   end

   // Tag compare, empty search, victim search and LRU update of the row.
   always_comb begin
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] empty_way;
      logic [WAY_W-1:0] vic_way;
      logic [AGE_W-1:0] hit_age;
      logic [AGE_W-1:0] vic_age;
      hit_any   = 1'b0;
      hit_way   = '0;
      hit_age   = '0;
      empty_any = 1'b0;
      empty_way = '0;
      vic_way   = '0;
      vic_age   = way_age[0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_act[w] && way_vld[w] && (way_tag[w] == tag_ff) && !hit_any) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
            hit_age = way_age[w];
         end
         if (way_act[w] && !way_vld[w] && !empty_any) begin
            empty_any = 1'b1;
            empty_way = WAY_W'(w);
         end
      end
      // Oldest active line, lowest way on a tie.
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (way_act[w] && (way_age[w] > vic_age)) begin
            vic_age = way_age[w];
            vic_way = WAY_W'(w);
         end
      end
      if (hit_any) begin
         keep_way   = hit_way;
         access_out = salc_pkg::OUT_HIT;
      end else if (empty_any) begin
         keep_way   = empty_way;
         access_out = salc_pkg::OUT_FILL;
      end else begin
         keep_way   = vic_way;
         access_out = salc_pkg::OUT_EVICT;
      end
      // Touched line becomes newest; younger lines, or all on a miss, age by one.
      row_new = row_word;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_act[w]) begin
            if (WAY_W'(w) == keep_way) begin
               row_new[w*ENT_W +: ENT_W] = {1'b1, tag_ff, {AGE_W{1'b0}}};
            end else if (way_vld[w] && (!hit_any || (way_age[w] < hit_age)) &&
                         (way_age[w] < AGE_MAX)) begin
               row_new[w*ENT_W +: AGE_W] = way_age[w] + AGE_W'(1);
            end
         end
      end
   end

   // Write back the set, update totals and load the result register.
   always_comb begin
      logic [salc_pkg::CNT_W:0] hit_sum;
      logic [salc_pkg::CNT_W:0] miss_sum;
      logic [salc_pkg::CNT_W:0] evict_sum;
      logic                     do_acc;
      do_acc       = (state_ff == ST_LOOK) && !ign_ff;
      ram_we       = do_acc;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      row_live_in  = row_live_ff;
      hit_sum      = {1'b0, hits_ff} + (salc_pkg::CNT_W + 1)'(hit_any) +
                     (salc_pkg::CNT_W + 1)'(mod_ff);
      miss_sum     = {1'b0, misses_ff} + (salc_pkg::CNT_W + 1)'(!hit_any);
      evict_sum    = {1'b0, evicts_ff} +
                     (salc_pkg::CNT_W + 1)'(access_out == salc_pkg::OUT_EVICT);
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      if (do_acc) begin
         hits_in   = hit_sum[salc_pkg::CNT_W] ? '1 : hit_sum[salc_pkg::CNT_W-1:0];
         misses_in = miss_sum[salc_pkg::CNT_W] ? '1 : miss_sum[salc_pkg::CNT_W-1:0];
         evicts_in = evict_sum[salc_pkg::CNT_W] ? '1 : evict_sum[salc_pkg::CNT_W-1:0];
         row_live_in[set_ff] = 1'b1;
      end
      rsp_data_in.outcome     = ign_ff ? salc_pkg::OUT_IGNORED : access_out;
      rsp_data_in.second_hit  = mod_ff && !ign_ff;
      rsp_data_in.hit_total   = hits_in;
      rsp_data_in.miss_total  = misses_in;
      rsp_data_in.evict_total = evicts_in;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      set_bits_in   = set_bits_ff;
      way_count_in  = way_count_ff;
      block_bits_in = block_bits_ff;
      if (csr_we) begin
         unique case (csr_index)
            salc_pkg::CSR_SET_BITS: begin
               set_bits_in = csr_wdata[salc_pkg::SET_BITS_W-1:0];
            end
            salc_pkg::CSR_WAY_COUNT: begin
               way_count_in = csr_wdata[salc_pkg::WAY_COUNT_W-1:0];
            end
            salc_pkg::CSR_BLOCK_BITS: begin
               block_bits_in = csr_wdata[salc_pkg::BLOCK_BITS_W-1:0];
            end
            default: begin
               set_bits_in = set_bits_ff;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         row_live_ff   <= '0;
         set_bits_ff   <= salc_pkg::SET_BITS_RST;
         way_count_ff  <= salc_pkg::WAY_COUNT_RST;
         block_bits_ff <= salc_pkg::BLOCK_BITS_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         row_live_ff   <= row_live_in;
         set_bits_ff   <= set_bits_in;
         way_count_ff  <= way_count_in;
         block_bits_ff <= block_bits_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         tag_ff <= tag_in;
         set_ff <= set_in;
         ign_ff <= ign_in;
         mod_ff <= mod_in;
      end
      if (state_ff == ST_LOOK) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // An accepted access raises the result valid register right after its lookup state.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> ##2 rsp_valid_ff)
      else $error("result not presented two cycles after the transfer");

   // The hit total never goes down.
   a_hits_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hits_ff >= $past(hits_ff)))
      else $error("hit total decreased");

   // Every eviction is also counted as a miss.
   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evicts_ff <= misses_ff)
      else $error("eviction total exceeds miss total");
`endif

endmodule

FILE: sim/tb_set_assoc_lru_cache_sim_unit.sv
`timescale 1ns / 1ps
// Testbench for set_assoc_lru_cache_sim_unit: a cache predictor in a small
// scoreboard class checks every result. Depends on salc_pkg and the RTL in src.
module tb_set_assoc_lru_cache_sim_unit;
   import salc_pkg::*;

   localparam int NUM_SETS = 1 << DEF_MAX_SET_BITS;
   localparam int NUM_WAYS = DEF_MAX_WAYS;
   localparam int MAX_SB   = DEF_MAX_SET_BITS;

   // Cache predictor and the queue of results it expects.
   class cache_scoreboard;
      bit        line_live [NUM_SETS][NUM_WAYS];
      bit [61:0] line_tag  [NUM_SETS][NUM_WAYS];
      bit [2:0]  line_age  [NUM_SETS][NUM_WAYS];
      bit [31:0] hit_count, miss_count, evict_count;
      bit [2:0]  set_bits_reg;
      bit [3:0]  way_count_reg;
      bit [5:0]  block_bits_reg;
      rsp_type   expected_results[$];
      int        error_count;

      function new();
         set_bits_reg   = SET_BITS_RST;
         way_count_reg  = WAY_COUNT_RST;
         block_bits_reg = BLOCK_BITS_RST;
      endfunction

      function void write_config(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_SET_BITS:   set_bits_reg = value[2:0];
            CSR_WAY_COUNT:  way_count_reg = value[3:0];
            CSR_BLOCK_BITS: block_bits_reg = value;
            default: ;
         endcase
      endfunction

      // Ages the other live lines of a set; only lines younger than the limit move.
      function void age_set(int set_idx, int ways, int keep, int limit);
         for (int w = 0; w < ways; w++) begin
            if (w != keep && line_live[set_idx][w] && int'(line_age[set_idx][w]) < limit &&
                line_age[set_idx][w] < 3'(NUM_WAYS - 1))
               line_age[set_idx][w]++;
         end
      endfunction

      // One lookup with fill or LRU replacement.
      function outcome_type touch_set(int set_idx, bit [61:0] tag, int ways);
         int pick;
         bit [2:0] oldest;
         for (int w = 0; w < ways; w++) begin
            if (line_live[set_idx][w] && line_tag[set_idx][w] == tag) begin
               age_set(set_idx, ways, w, int'(line_age[set_idx][w]));
               line_age[set_idx][w] = '0;
               if (hit_count != '1) hit_count++;
               return OUT_HIT;
            end
         end
         if (miss_count != '1) miss_count++;
         for (int w = 0; w < ways; w++) begin
            if (!line_live[set_idx][w]) begin
               age_set(set_idx, ways, w, 256);
               line_live[set_idx][w] = 1'b1;
               line_tag[set_idx][w] = tag;
               line_age[set_idx][w] = '0;
               return OUT_FILL;
            end
         end
         if (evict_count != '1) evict_count++;
         pick = 0;
         oldest = line_age[set_idx][0];
         for (int w = 1; w < ways; w++) begin
            if (line_age[set_idx][w] > oldest) begin
               oldest = line_age[set_idx][w];
               pick = w;
            end
         end
         age_set(set_idx, ways, pick, 256);
         line_tag[set_idx][pick] = tag;
         line_age[set_idx][pick] = '0;
         return OUT_EVICT;
      endfunction

      // Called for every accepted access transfer.
      function void note_access(req_type item);
         rsp_type want;
         int eff_sb, ways, shift, set_idx;
         bit [61:0] tag;
         want = '0;
         want.outcome = OUT_IGNORED;
         if (item.cmd != CMD_IFETCH) begin
            eff_sb = (set_bits_reg > MAX_SB) ? MAX_SB : int'(set_bits_reg);
            ways = (way_count_reg == 0) ? 1 :
                   (way_count_reg > NUM_WAYS) ? NUM_WAYS : int'(way_count_reg);
            shift = int'(block_bits_reg) + eff_sb;
            tag = (shift >= 64) ? '0 : 62'(item.addr >> shift);
            set_idx = int'((item.addr >> block_bits_reg) & ((64'd1 << eff_sb) - 64'd1));
            want.outcome = touch_set(set_idx, tag, ways);
            // The second access of a modify always hits the line just touched.
            if (item.cmd == CMD_MODIFY) begin
               void'(touch_set(set_idx, tag, ways));
               want.second_hit = 1'b1;
            end
         end
         want.hit_total = hit_count;
         want.miss_total = miss_count;
         want.evict_total = evict_count;
         expected_results.push_back(want);
      endfunction

      function void compare_field(string name, bit [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            error_count++;
         end
      endfunction

      // Called for every accepted result transfer.
      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $error("result transfer with no access outstanding: %h", got);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
         compare_field("second_hit", 32'(want.second_hit), 32'(got.second_hit));
         compare_field("hit_total", want.hit_total, got.hit_total);
         compare_field("miss_total", want.miss_total, got.miss_total);
         compare_field("evict_total", want.evict_total, got.evict_total);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   cache_scoreboard board = new();
   int  req_taken = 0;
   bit  calm = 1'b0;
   bit  sink_hold_request = 1'b0;

   set_assoc_lru_cache_sim_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Sample every transfer and register write at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.write_config(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (req_valid && req_ready) begin
            board.note_access(req_data);
            req_taken++;
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int quiet_left;
      quiet_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            quiet_left = 300;
         end else if (quiet_left == 0 && !calm && $urandom_range(0, 5) == 0) begin
            quiet_left = $urandom_range(1, 18);
         end
         if (quiet_left > 0) begin
            rsp_ready <= 1'b0;
            quiet_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one access and waits for its transfer, then maybe idles.
   task automatic send_access(cmd_type cmd, logic [63:0] addr);
      req_type item;
      int seen;
      item.cmd = cmd;
      item.addr = addr;
      seen = req_taken;
      req_valid <= 1'b1;
      req_data <= item;
      do @(negedge clock); while (req_taken == seen);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   task automatic drop_request();
      if (req_valid) req_valid <= 1'b0;
   endtask

   // Sender pause until every expected result has come back.
   task automatic wait_drained();
      @(negedge clock);
      while (board.expected_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(bit [2:0] sb, bit [3:0] wc, bit [5:0] bb);
      csr_we <= 1'b1;
      csr_index <= CSR_SET_BITS;
      csr_wdata <= 6'(sb);
      @(negedge clock);
      csr_index <= CSR_WAY_COUNT;
      csr_wdata <= 6'(wc);
      @(negedge clock);
      csr_index <= CSR_BLOCK_BITS;
      csr_wdata <= bb;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Builds an address with a small tag and one of a few sets, so that lines repeat.
   function automatic logic [63:0] near_addr(int eff_sb, int bb);
      logic [63:0] offset_mask, set_mask, addr;
      int shift;
      shift = bb + eff_sb;
      offset_mask = (64'd1 << bb) - 64'd1;
      set_mask = ((64'd1 << shift) - 64'd1) & ~offset_mask;
      addr = {$urandom, $urandom} & offset_mask;
      addr |= (64'($urandom_range(0, 3)) << bb) & set_mask;
      addr |= 64'($urandom_range(0, 9)) << shift;
      return addr;
   endfunction

   // One configuration followed by random accesses; halfway the sender drains.
   task automatic run_phase(int count, bit [2:0] sb, bit [3:0] wc, bit [5:0] bb,
                            bit squeeze);
      logic [63:0] recent[$];
      logic [63:0] addr;
      cmd_type cmd;
      int done, eff_sb, pick;
      done = 0;
      eff_sb = (sb > MAX_SB) ? MAX_SB : int'(sb);
      wait_drained();
      configure(sb, wc, bb);
      if (squeeze) sink_hold_request = 1'b1;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) cmd = CMD_IFETCH;
         else if (pick < 30) cmd = CMD_MODIFY;
         else if (pick < 65) cmd = CMD_LOAD;
         else cmd = CMD_STORE;
         pick = $urandom_range(0, 99);
         if (pick < 45 && recent.size() != 0)
            addr = recent[$urandom_range(0, recent.size() - 1)];
         else if (pick < 88)
            addr = near_addr(eff_sb, int'(bb));
         else
            addr = {$urandom, $urandom};
         recent.push_back(addr);
         if (recent.size() > 12) void'(recent.pop_front());
         send_access(cmd, addr);
         if (cmd != CMD_IFETCH) done++;
         if (done == count / 2 && cmd != CMD_IFETCH) begin
            drop_request();
            wait_drained();
         end
      end
      drop_request();
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset split: four set bits, one way, four offset bits.
      send_access(CMD_IFETCH, 64'd0);
      send_access(CMD_LOAD, 64'd0);
      send_access(CMD_LOAD, 64'h0F);
      send_access(CMD_STORE, 64'h100);
      send_access(CMD_MODIFY, 64'h100);
      send_access(CMD_MODIFY, 64'h200);
      send_access(CMD_LOAD, '1);
      send_access(CMD_STORE, '1);
      send_access(CMD_IFETCH, '1);
      drop_request();

      // Narrow split with a single set: the top tag bits alias.
      wait_drained();
      configure(3'd0, 4'd8, 6'd0);
      send_access(CMD_LOAD, 64'd0);
      send_access(CMD_LOAD, 64'hC000_0000_0000_0000);
      send_access(CMD_STORE, 64'h4000_0000_0000_0000);
      send_access(CMD_LOAD, 64'd1);
      send_access(CMD_LOAD, 64'd2);
      send_access(CMD_LOAD, 64'd3);
      send_access(CMD_LOAD, 64'd4);
      drop_request();

      // Wide split: clamped set bits and ways, tag always zero.
      wait_drained();
      configure(3'd7, 4'd15, 6'd63);
      send_access(CMD_LOAD, 64'd0);
      send_access(CMD_LOAD, 64'h8000_0000_0000_0000);
      send_access(CMD_MODIFY, '1);
      send_access(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
      drop_request();

      // Offset plus set bits exactly 64.
      wait_drained();
      configure(3'd6, 4'd8, 6'd58);
      send_access(CMD_LOAD, '1);
      send_access(CMD_STORE, 64'hFC00_0000_0000_0000);
      drop_request();

      run_phase(90, 3'd0, 4'd0, 6'd0, 1'b0);
      run_phase(90, 3'd7, 4'd15, 6'd63, 1'b0);
      run_phase(90, 3'd6, 4'd8, 6'd58, 1'b0);
      run_phase(90, 3'd1, 4'd1, 6'd1, 1'b0);
      run_phase(90, 3'd6, 4'd8, 6'd1, 1'b1);
      run_phase(90, 3'd2, 4'd2, 6'd4, 1'b0);
      run_phase(90, 3'd3, 4'd4, 6'd6, 1'b0);
      repeat (3) begin
         run_phase(90, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                   ($urandom_range(0, 5) == 0) ? 6'($urandom_range(48, 63))
                                               : 6'($urandom_range(0, 12)), 1'b0);
      end
      calm = 1'b1;
      run_phase(90, 3'd2, 4'd8, 6'd3, 1'b0);

      wait_drained();
      repeat (10) @(negedge clock);
      if (board.error_count == 0 && board.expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: sim.f
src/salc_pkg.sv
src/salc_ram.sv
src/set_assoc_lru_cache_sim_unit.sv
sim/tb_set_assoc_lru_cache_sim_unit.sv
